### sv/mclw_pkg.sv
`default_nettype none

package mclw_pkg;

   // Field widths that the item formats fix.
   localparam int MODE_W    = 3;
   localparam int CHAN_W    = 3;
   localparam int LIMIT_W   = 32;
   localparam int UPC_W     = 3;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REFRESH = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ATTACH  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DETACH  = 3'd4;

   // Result event codes.
   localparam logic EV_LOST      = 1'b0;
   localparam logic EV_RECOVERED = 1'b1;

   // Microprogram step addresses.
   localparam logic [UPC_W-1:0] UPC_FETCH   = 3'd0;
   localparam logic [UPC_W-1:0] UPC_TICK    = 3'd1;
   localparam logic [UPC_W-1:0] UPC_REFRESH = 3'd2;
   localparam logic [UPC_W-1:0] UPC_CLEAR   = 3'd3;
   localparam logic [UPC_W-1:0] UPC_EVAL    = 3'd4;
   localparam logic [UPC_W-1:0] UPC_EMIT    = 3'd5;
   localparam logic [UPC_W-1:0] UPC_ATTACH  = 3'd6;
   localparam logic [UPC_W-1:0] UPC_DETACH  = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CHAN_W-1:0]  channel;
      logic [LIMIT_W-1:0] limit;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel_out;
      logic              event_res;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_TICK,
      UOP_REFRESH,
      UOP_CLEAR,
      UOP_EVAL,
      UOP_EMIT,
      UOP_ATTACH,
      UOP_DETACH
   } uop_type;

   typedef enum logic [2:0] {
      COND_SEQ,
      COND_JUMP,
      COND_DISPATCH,
      COND_LOOP,
      COND_DRAIN
   } cond_type;

   typedef struct packed {
      logic             ready;
      uop_type          op;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic stall;
      logic idx_end;
      logic pend_empty;
   } status_type;

   // Control store.
   function automatic ctrl_word_type rom_word(input logic [UPC_W-1:0] upc);
      ctrl_word_type w;
      w = '{ready: 1'b0, op: UOP_NOP, cond: COND_JUMP, target: UPC_FETCH};
      case (upc)
         UPC_FETCH:   w = '{ready: 1'b1, op: UOP_NOP, cond: COND_DISPATCH, target: UPC_FETCH};
         UPC_TICK:    w = '{ready: 1'b0, op: UOP_TICK, cond: COND_JUMP, target: UPC_FETCH};
         UPC_REFRESH: w = '{ready: 1'b0, op: UOP_REFRESH, cond: COND_JUMP, target: UPC_FETCH};
         UPC_CLEAR:   w = '{ready: 1'b0, op: UOP_CLEAR, cond: COND_SEQ, target: UPC_FETCH};
         UPC_EVAL:    w = '{ready: 1'b0, op: UOP_EVAL, cond: COND_LOOP, target: UPC_EVAL};
         UPC_EMIT:    w = '{ready: 1'b0, op: UOP_EMIT, cond: COND_DRAIN, target: UPC_FETCH};
         UPC_ATTACH:  w = '{ready: 1'b0, op: UOP_ATTACH, cond: COND_JUMP, target: UPC_FETCH};
         UPC_DETACH:  w = '{ready: 1'b0, op: UOP_DETACH, cond: COND_JUMP, target: UPC_FETCH};
         default:     w = '{ready: 1'b0, op: UOP_NOP, cond: COND_JUMP, target: UPC_FETCH};
      endcase
      return w;
   endfunction

   // Entry point of each mode's routine.
   function automatic logic [UPC_W-1:0] dispatch(input logic [MODE_W-1:0] mode);
      logic [UPC_W-1:0] a;
      a = UPC_FETCH;
      case (mode)
         MODE_TICK:    a = UPC_TICK;
         MODE_REFRESH: a = UPC_REFRESH;
         MODE_CHECK:   a = UPC_CLEAR;
         MODE_ATTACH:  a = UPC_ATTACH;
         MODE_DETACH:  a = UPC_DETACH;
         default:      a = UPC_FETCH;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

### sv/multi_channel_loss_watchdog.sv
`default_nettype none

// Multi-channel loss watchdog. Each item on the req_ channel either advances
// the tick counter by one, attaches a channel with a timeout limit,
// detaches it, refreshes it, or checks all channels. A check reports a lost
// event for every active channel whose elapsed time since its last refresh,
// wrapped to TIME_WIDTH bits, is greater than its limit, in ascending channel
// order, and it repeats the report on every check while the channel stays
// lost. A refresh of a lost channel reports a recovered event. The last
// result of an item carries last set. Attach sets the refresh time to zero,
// not to the current tick count. Control is a small microprogram: a step
// counter walks a read-only table of control words that drives the
// datapath, one word per cycle unless a stall holds the step counter.
// Tick, refresh, attach and detach pass through the fetch step and one
// work step; an item with an unused mode is dropped in the fetch step
// itself. A check goes from the fetch step to a clear step, then walks
// the per-channel limit and refresh-time memories, one entry per cycle, in
// its evaluation step, then its emit step moves over each channel index up
// to and including the highest lost one, plus one closing pass. A step that
// must store a result waits while the output register still holds an
// untaken item. A new item is accepted only in the fetch step; a finished
// result may still be waiting in the output register at that time.
module multi_channel_loss_watchdog #(
   parameter int CHANNELS   = 8,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire mclw_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output mclw_pkg::rsp_type        rsp_data
);

   mclw_pkg::ctrl_word_type ctrl;
   mclw_pkg::status_type    status;

   mclw_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .status    (status),
      .ctrl      (ctrl)
   );

   mclw_datapath #(
      .CHANNELS   (CHANNELS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_accept (req_valid && req_ready),
      .req_data   (req_data),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .status     (status)
   );

   // The fetch step accepts items; it is the only step that drives ready.
   assign req_ready = ctrl.ready;

   // No lost reports remain pending once the sequencer is back at fetch.
   a_fetch_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> status.pend_empty)
      else $error("pending lost reports left at fetch");

   // An item with a defined mode always leaves the fetch step for its routine.
   a_dispatch_leaves_fetch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.mode == mclw_pkg::MODE_TICK
         || req_data.mode == mclw_pkg::MODE_REFRESH
         || req_data.mode == mclw_pkg::MODE_CHECK
         || req_data.mode == mclw_pkg::MODE_ATTACH
         || req_data.mode == mclw_pkg::MODE_DETACH)) |=> !req_ready)
      else $error("sequencer did not leave fetch after an item");

   // A recovered event is the only result of its refresh item.
   a_recovered_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.event_res == mclw_pkg::EV_RECOVERED)) |-> rsp_data.last)
      else $error("recovered event without last");

endmodule

`default_nettype wire

### sv/mclw_sequencer.sv
`default_nettype none

module mclw_sequencer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [mclw_pkg::MODE_W-1:0]   req_mode,
   input  wire mclw_pkg::status_type          status,
   output mclw_pkg::ctrl_word_type            ctrl
);

   logic [mclw_pkg::UPC_W-1:0] upc_ff;
   logic [mclw_pkg::UPC_W-1:0] upc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= mclw_pkg::UPC_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // Next step.
   always_comb begin
      upc_in = upc_ff;
      if (!status.stall) begin
         case (ctrl.cond)
            mclw_pkg::COND_SEQ:      upc_in = upc_ff + 1'b1;
            mclw_pkg::COND_JUMP:     upc_in = ctrl.target;
            mclw_pkg::COND_DISPATCH: upc_in = req_valid ? mclw_pkg::dispatch(req_mode) : upc_ff;
            mclw_pkg::COND_LOOP:     upc_in = status.idx_end ? upc_ff + 1'b1 : ctrl.target;
            mclw_pkg::COND_DRAIN:    upc_in = status.pend_empty ? ctrl.target : upc_ff;
            default:                 upc_in = mclw_pkg::UPC_FETCH;
         endcase
      end
   end

   // Control word of the current step.
   always_comb begin
      ctrl = mclw_pkg::rom_word(upc_ff);
   end

endmodule

`default_nettype wire

### sv/mclw_datapath.sv
`default_nettype none

module mclw_datapath #(
   parameter int CHANNELS   = 8,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mclw_pkg::ctrl_word_type  ctrl,
   input  wire logic                     req_accept,
   input  wire mclw_pkg::req_type        req_data,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output mclw_pkg::rsp_type             rsp_data,
   output mclw_pkg::status_type          status
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W = (TIME_WIDTH > mclw_pkg::LIMIT_W) ? TIME_WIDTH : mclw_pkg::LIMIT_W;

   mclw_pkg::req_type            item_ff;
   logic [TIME_WIDTH-1:0]        now_ff, now_in;
   logic [CHANNELS-1:0]          active_ff, active_in;
   logic [CHANNELS-1:0]          lost_ff, lost_in;
   logic [CHANNELS-1:0]          pend_ff, pend_in;
   logic [CHANNELS-1:0]          pend_rest;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   mclw_pkg::rsp_type            rsp_ff, rsp_in;

   logic [mclw_pkg::LIMIT_W-1:0] limit_mem [CHANNELS];
   logic [TIME_WIDTH-1:0]        refresh_mem [CHANNELS];
   logic [mclw_pkg::LIMIT_W-1:0] lim_rd_ff;
   logic [TIME_WIDTH-1:0]        ref_rd_ff;

   logic                         ch_ok;
   logic [IDX_W-1:0]             ch_idx;
   logic                         emit_refresh, emit_check, emit_want, go;
   logic                         idx_end, hit;
   logic [TIME_WIDTH-1:0]        elapsed;
   logic                         lim_we, ref_we;
   logic [TIME_WIDTH-1:0]        ref_wdata;

   assign ch_ok   = 32'(item_ff.channel) < 32'(CHANNELS);
   assign ch_idx  = IDX_W'(item_ff.channel);
   assign idx_end = idx_ff == IDX_W'(CHANNELS - 1);
   assign elapsed = now_ff - ref_rd_ff;
   assign hit     = active_ff[idx_ff] && (CMP_W'(elapsed) > CMP_W'(lim_rd_ff));

   assign emit_refresh = (ctrl.op == mclw_pkg::UOP_REFRESH) && ch_ok
                         && active_ff[ch_idx] && lost_ff[ch_idx];
   assign emit_check   = (ctrl.op == mclw_pkg::UOP_EMIT) && pend_ff[idx_ff];
   assign emit_want    = emit_refresh || emit_check;
   assign go           = !(emit_want && rsp_valid_ff && !rsp_ready);

   assign lim_we    = (ctrl.op == mclw_pkg::UOP_ATTACH) && ch_ok;
   assign ref_we    = lim_we || ((ctrl.op == mclw_pkg::UOP_REFRESH) && go && ch_ok
                                 && active_ff[ch_idx]);
   assign ref_wdata = (ctrl.op == mclw_pkg::UOP_ATTACH) ? '0 : now_ff;

   always_comb begin
      pend_rest         = pend_ff;
      pend_rest[idx_ff] = 1'b0;
   end

   always_comb begin
      now_in    = now_ff;
      active_in = active_ff;
      lost_in   = lost_ff;
      pend_in   = pend_ff;
      idx_in    = idx_ff;
      case (ctrl.op)
         mclw_pkg::UOP_TICK: begin
            now_in = now_ff + 1'b1;
         end
         mclw_pkg::UOP_REFRESH: begin
            if (emit_refresh && go) begin
               lost_in[ch_idx] = 1'b0;
            end
         end
         mclw_pkg::UOP_CLEAR: begin
            pend_in = '0;
            idx_in  = '0;
         end
         mclw_pkg::UOP_EVAL: begin
            pend_in[idx_ff] = pend_ff[idx_ff] | hit;
            lost_in[idx_ff] = lost_ff[idx_ff] | hit;
            idx_in          = idx_end ? '0 : idx_ff + 1'b1;
         end
         mclw_pkg::UOP_EMIT: begin
            if (go && (pend_ff != '0)) begin
               pend_in = pend_rest;
               idx_in  = idx_end ? '0 : idx_ff + 1'b1;
            end
         end
         mclw_pkg::UOP_ATTACH: begin
            if (ch_ok) begin
               active_in[ch_idx] = 1'b1;
               lost_in[ch_idx]   = 1'b0;
            end
         end
         mclw_pkg::UOP_DETACH: begin
            if (ch_ok) begin
               active_in[ch_idx] = 1'b0;
               lost_in[ch_idx]   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (emit_want && go);
      rsp_in       = rsp_ff;
      if (emit_want && go) begin
         if (emit_refresh) begin
            rsp_in = '{channel_out: item_ff.channel, event_res: mclw_pkg::EV_RECOVERED,
                       last: 1'b1};
         end else begin
            rsp_in = '{channel_out: mclw_pkg::CHAN_W'(idx_ff), event_res: mclw_pkg::EV_LOST,
                       last: (pend_rest == '0)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         active_ff    <= '0;
         lost_ff      <= '0;
         pend_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         active_ff    <= active_in;
         lost_ff      <= lost_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // Limit and refresh-time stores, read ahead at the next walk index.
   always_ff @(posedge clock) begin
      if (lim_we) begin
         limit_mem[ch_idx] <= item_ff.limit;
      end
      if (ref_we) begin
         refresh_mem[ch_idx] <= ref_wdata;
      end
      lim_rd_ff <= limit_mem[idx_in];
      ref_rd_ff <= refresh_mem[idx_in];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;
   assign status.stall      = !go;
   assign status.idx_end    = idx_end;
   assign status.pend_empty = pend_ff == '0;

endmodule

`default_nettype wire

### test/multi_channel_loss_watchdog_tb.sv
`timescale 1ns / 1ps

module multi_channel_loss_watchdog_tb;

   localparam int NUM_CHAN     = 8;
   localparam int TICK_W       = 32;
   localparam int MAX_EVENTS   = 8;
   localparam int RANDOM_ITEMS = 200;
   localparam int N_DIRECTED   = 25;

   // Modes 5 to 7 carry no meaning; the block must swallow them without a result.
   localparam logic [mclw_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [mclw_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   // A check walks all channels and then emits its results, so DRAIN_CYCLES
   // covers any silent work still in flight.
   localparam int DRAIN_CYCLES = 40;
   // The receiver's long hold-off starts once this many items have gone in.
   localparam int HOLD_AT      = 110;
   localparam int HOLD_CYCLES  = 400;
   // Worst case is about 225 items, each a full check with eight results that
   // each wait out a receiver stall, plus sender gaps.
   localparam int CYCLE_LIMIT  = 500000;

   // One row of the directed table. When pinned is set, the expected result is
   // written out in the row (has_ev says whether there is one at all); the
   // predictor still runs so that its state follows the block.
   typedef struct packed {
      mclw_pkg::req_type item;
      logic              pinned;
      logic              has_ev;
      mclw_pkg::rsp_type ev;
   } dir_row_type;

   localparam mclw_pkg::rsp_type NO_EV = '0;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mclw_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   mclw_pkg::rsp_type rsp_data;

   // Predictor state: a copy of the watchdog table.
   logic [TICK_W-1:0] tick_count;
   logic              chan_active [NUM_CHAN];
   logic [TICK_W-1:0] chan_limit  [NUM_CHAN];
   logic [TICK_W-1:0] chan_seen   [NUM_CHAN];
   logic              chan_lost   [NUM_CHAN];

   // Events that the predictor produced for the latest item, and the events
   // that the block still owes us, oldest first.
   mclw_pkg::rsp_type fresh_events [$];
   mclw_pkg::rsp_type due_events   [$];

   int error_count;
   int items_taken;
   int cycle_count;

   dir_row_type dir_tab [N_DIRECTED];

   multi_channel_loss_watchdog #(
      .CHANNELS  (NUM_CHAN),
      .TIME_WIDTH(TICK_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the predictor by one item and leave its events in fresh_events.
   // A check reports lost channels in ascending order; a refresh of a lost
   // channel reports it recovered; everything else is silent.
   task automatic watchdog_predict(input mclw_pkg::req_type it);
      logic [TICK_W-1:0] elapsed;
      int                ch;
      mclw_pkg::rsp_type ev;
      fresh_events.delete();
      ch = int'(it.channel);
      case (it.mode)
         mclw_pkg::MODE_TICK: begin
            tick_count = tick_count + 1'b1;
         end
         mclw_pkg::MODE_REFRESH: begin
            if (ch < NUM_CHAN && chan_active[ch]) begin
               if (chan_lost[ch]) begin
                  chan_lost[ch] = 1'b0;
                  ev = '{channel_out: it.channel, event_res: mclw_pkg::EV_RECOVERED,
                         last: 1'b0};
                  fresh_events.push_back(ev);
               end
               chan_seen[ch] = tick_count;
            end
         end
         mclw_pkg::MODE_CHECK: begin
            for (int i = 0; i < NUM_CHAN; i++) begin
               if (chan_active[i]) begin
                  // Unsigned subtraction at the tick width gives the wrapped age.
                  elapsed = tick_count - chan_seen[i];
                  if (elapsed > chan_limit[i]) begin
                     chan_lost[i] = 1'b1;
                     if (fresh_events.size() < MAX_EVENTS) begin
                        ev = '{channel_out: mclw_pkg::CHAN_W'(i),
                               event_res: mclw_pkg::EV_LOST, last: 1'b0};
                        fresh_events.push_back(ev);
                     end
                  end
               end
            end
         end
         mclw_pkg::MODE_ATTACH: begin
            // Attach restarts the channel from time zero, not from the current tick.
            if (ch < NUM_CHAN) begin
               chan_active[ch] = 1'b1;
               chan_limit[ch]  = it.limit;
               chan_seen[ch]   = '0;
               chan_lost[ch]   = 1'b0;
            end
         end
         mclw_pkg::MODE_DETACH: begin
            if (ch < NUM_CHAN) begin
               chan_active[ch] = 1'b0;
               chan_lost[ch]   = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (fresh_events.size() > 0)
         fresh_events[fresh_events.size()-1].last = 1'b1;
   endtask

   // Offer one item, hold it until the block takes it, then record what the
   // block now owes. The sender works in bursts: when a burst runs out, it may
   // drop valid for a random gap before the next one starts. Valid is only
   // lowered at the start of a gap, so it is never lowered and raised again in
   // the same time step.
   int burst_left = 0;

   task automatic send_item(input mclw_pkg::req_type it, input logic pinned,
                            input logic has_ev, input mclw_pkg::rsp_type ev);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      watchdog_predict(it);
      if (pinned) begin
         if (has_ev)
            due_events.push_back(ev);
      end else begin
         foreach (fresh_events[k])
            due_events.push_back(fresh_events[k]);
      end
      items_taken++;
   endtask

   // Random items lean on ticks, refreshes and checks so that channels both
   // time out and recover. Most limits are small so that losses actually
   // happen; the rest span the full 32 bits. Fields that a mode ignores still
   // get random bits.
   function automatic mclw_pkg::req_type random_item();
      mclw_pkg::req_type it;
      int                pick;
      pick       = $urandom_range(0, 99);
      it.channel = mclw_pkg::CHAN_W'($urandom_range(0, NUM_CHAN - 1));
      it.limit   = $urandom;
      if (pick < 33)
         it.mode = mclw_pkg::MODE_TICK;
      else if (pick < 53)
         it.mode = mclw_pkg::MODE_REFRESH;
      else if (pick < 73)
         it.mode = mclw_pkg::MODE_CHECK;
      else if (pick < 88) begin
         it.mode = mclw_pkg::MODE_ATTACH;
         if ($urandom_range(0, 3) != 0)
            it.limit = $urandom_range(0, 12);
      end else if (pick < 95)
         it.mode = mclw_pkg::MODE_DETACH;
      else
         it.mode = mclw_pkg::MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      return it;
   endfunction

   // Directed sequence. The tick counter is zero after reset, so the first
   // rows can be worked out by hand: a channel attached with limit zero is
   // lost as soon as one tick passes, and is reported again on every check
   // until a refresh brings it back. The later rows lose several channels at
   // once, re-attach a lost channel, and detach one.
   initial begin
      dir_tab = '{
         // Check with nothing attached.
         '{'{mclw_pkg::MODE_CHECK,   3'd0, 32'h0000_0000}, 1'b1, 1'b0, NO_EV},
         // Refresh of a channel that was never attached.
         '{'{mclw_pkg::MODE_REFRESH, 3'd3, 32'hFFFF_FFFF}, 1'b1, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd0, 32'h0000_0000}, 1'b1, 1'b0, NO_EV},
         // Elapsed time zero is not greater than a limit of zero.
         '{'{mclw_pkg::MODE_CHECK,   3'd0, 32'h0000_0000}, 1'b1, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_TICK,    3'd0, 32'h0000_0000}, 1'b1, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_CHECK,   3'd0, 32'h0000_0000}, 1'b1, 1'b1,
           '{3'd0, mclw_pkg::EV_LOST, 1'b1}},
         // A lost channel is reported again on the next check.
         '{'{mclw_pkg::MODE_CHECK,   3'd5, 32'h8000_0001}, 1'b1, 1'b1,
           '{3'd0, mclw_pkg::EV_LOST, 1'b1}},
         '{'{mclw_pkg::MODE_REFRESH, 3'd0, 32'h0000_0000}, 1'b1, 1'b1,
           '{3'd0, mclw_pkg::EV_RECOVERED, 1'b1}},
         // A second refresh finds the channel healthy.
         '{'{mclw_pkg::MODE_REFRESH, 3'd0, 32'h0000_0000}, 1'b1, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd7, 32'hFFFF_FFFF}, 1'b1, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd1, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd2, 32'h0000_0001}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd3, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd4, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd5, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd6, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_TICK,    3'd7, 32'hFFFF_FFFF}, 1'b0, 1'b0, NO_EV},
         // Seven channels lost in one check; the one with the largest limit is not.
         '{'{mclw_pkg::MODE_CHECK,   3'd0, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         // Attach over an already active channel, then over a lost one.
         '{'{mclw_pkg::MODE_ATTACH,  3'd7, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_ATTACH,  3'd0, 32'h0000_0005}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_DETACH,  3'd1, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         '{'{mclw_pkg::MODE_CHECK,   3'd0, 32'h0000_0000}, 1'b0, 1'b0, NO_EV},
         // Refresh of a detached channel is ignored.
         '{'{mclw_pkg::MODE_REFRESH, 3'd1, 32'h0000_0000}, 1'b1, 1'b0, NO_EV},
         // Unused modes do nothing.
         '{'{MODE_SPARE_LO, 3'd2, 32'h0000_0000}, 1'b1, 1'b0, NO_EV},
         '{'{MODE_SPARE_HI, 3'd6, 32'hFFFF_FFFF}, 1'b1, 1'b0, NO_EV}
      };
   end

   // Main sequence: reset, directed table, random items, then drain.
   initial begin
      error_count = 0;
      items_taken = 0;
      tick_count  = '0;
      for (int i = 0; i < NUM_CHAN; i++) begin
         chan_active[i] = 1'b0;
         chan_limit[i]  = '0;
         chan_seen[i]   = '0;
         chan_lost[i]   = 1'b0;
      end
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[r])
         send_item(dir_tab[r].item, dir_tab[r].pinned, dir_tab[r].has_ev, dir_tab[r].ev);

      repeat (RANDOM_ITEMS)
         send_item(random_item(), 1'b0, 1'b0, NO_EV);

      req_valid <= 1'b0;
      // Wait for every owed event, then give any silent work time to settle so
      // that a stray late result is still caught by the monitor.
      while (due_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (due_events.size() != 0) begin
         $error("%0d expected events never arrived", due_events.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver: stretches of steady acceptance, random stalls and toggling,
   // each of random length. Once, partway through, it stops taking results
   // for a long stretch while the sender keeps offering, so the output
   // register stays full and the block has to hold off its input.
   initial begin
      int  style;
      int  run_len;
      bit  held_off;
      held_off = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && items_taken >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         style   = $urandom_range(0, 3);
         run_len = $urandom_range(5, 40);
         repeat (run_len) begin
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ~rsp_ready;
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Every result taken is matched, field by field, against the oldest owed event.
   always @(posedge clock) begin
      mclw_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_events.size() == 0) begin
            $error("unexpected result: channel_out %0d event_res %0d last %0d",
                   rsp_data.channel_out, rsp_data.event_res, rsp_data.last);
            error_count++;
         end else begin
            want = due_events.pop_front();
            if (rsp_data.channel_out !== want.channel_out) begin
               $error("channel_out: expected %0d, got %0d", want.channel_out,
                      rsp_data.channel_out);
               error_count++;
            end
            if (rsp_data.event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_data.event_res);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Guard against a hung handshake.
   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

### filelist.f
sv/mclw_pkg.sv
sv/mclw_sequencer.sv
sv/mclw_datapath.sv
sv/multi_channel_loss_watchdog.sv
test/multi_channel_loss_watchdog_tb.sv
